@@ hdl/sli_pkg.sv @@
// Shared types and constants for the sorted list insert block.
// Used by sli_store and sorted_list_insert_top; depends on nothing else.
`default_nettype none

package sli_pkg;

    localparam int DEPTH  = 16;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int DATA_W = 32;

    localparam logic [1:0] REQ_FRONT = 2'd0;
    localparam logic [1:0] REQ_BACK  = 2'd1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_UNSORTED = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_WRITE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic                     rd_en;
        logic [IDX_W-1:0]         rd_addr;
        logic                     wr_en;
        logic [IDX_W-1:0]         wr_addr;
        logic signed [DATA_W-1:0] wr_data;
    } mem_req_t;

endpackage

`default_nettype wire

@@ hdl/sli_store.sv @@
// Entry store of the sorted list: one write port and one registered read port.
// Depends on sli_pkg for the depth, widths and the port request struct.
`default_nettype none

module sli_store
    import sli_pkg::*;
(
    input  wire logic                     clk,
    input  wire mem_req_t                 req,
    output logic signed [DATA_W-1:0]      rd_data
);

    logic signed [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/sorted_list_insert_top.sv @@
// Sorted list insert block: sequencer, head/tail tracking and result register.
// Depends on sli_pkg and sli_store.
//
// Usage: each request on the slave stream carries a value in tdata and the
// request kind in tuser (front push, back push, ascending insert). Every
// request yields exactly one result on the master stream: status in tuser,
// and head, tail and entry count in tdata.
// An ascending insert first reads all stored entries through the single
// read port of the entry store, checking order and finding the insert
// position. Any accepted insert then moves the entries behind the position
// up by one, a read and a write overlapped per entry, then writes the new
// value and loads the result. A push refused as full goes straight to
// loading its result, with no scan and no move. The store's read port sets
// the time.
// Requests are taken one at a time; tready is high only while idle.
// Reset empties the list at once; the entries need no clearing.
// A stalled result waits in the output register; the next request may be
// accepted meanwhile, but its result is held back until the slot frees.
`default_nettype none

module sorted_list_insert_top
    import sli_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [31:0]  s_axis_tdata,   // value[31:0]
    input  wire logic [1:0]   s_axis_tuser,   // req_type[1:0]
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [71:0]       m_axis_tdata,   // head_value[31:0], tail_value[63:32],
                                              // entry_count[68:64], zero fill[71:69]
    output logic [1:0]        m_axis_tuser    // status[1:0]
);

    state_t                   state_reg, state_next;
    logic signed [DATA_W-1:0] value_reg, value_next;
    logic [CNT_W-1:0]         len_reg, len_next;
    logic signed [DATA_W-1:0] head_reg, head_next;
    logic signed [DATA_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0]         idx_reg, idx_next;
    logic                     pend_reg, pend_next;
    logic [IDX_W-1:0]         pend_idx_reg, pend_idx_next;
    logic signed [DATA_W-1:0] prev_reg, prev_next;
    logic                     unsorted_reg, unsorted_next;
    logic                     found_reg, found_next;
    logic [CNT_W-1:0]         pos_reg, pos_next;
    status_t                  status_reg, status_next;

    logic                     out_valid_reg, out_valid_next;
    status_t                  out_status_reg, out_status_next;
    logic signed [DATA_W-1:0] out_head_reg, out_head_next;
    logic signed [DATA_W-1:0] out_tail_reg, out_tail_next;
    logic [CNT_W-1:0]         out_count_reg, out_count_next;

    mem_req_t                 mem_req;
    logic signed [DATA_W-1:0] rd_data;
    logic                     in_accept;
    logic                     list_full;
    logic [CNT_W-1:0]         scan_pos;
    logic [CNT_W-1:0]         shift_addr;

    sli_store u_store (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign list_full     = (len_reg == CNT_W'(DEPTH));
    assign scan_pos      = found_reg ? pos_reg : len_reg;
    assign shift_addr    = pos_reg + idx_reg - CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg      <= value_next;
        head_reg       <= head_next;
        tail_reg       <= tail_next;
        idx_reg        <= idx_next;
        pend_idx_reg   <= pend_idx_next;
        prev_reg       <= prev_next;
        unsorted_reg   <= unsorted_next;
        found_reg      <= found_next;
        pos_reg        <= pos_next;
        status_reg     <= status_next;
        out_status_reg <= out_status_next;
        out_head_reg   <= out_head_next;
        out_tail_reg   <= out_tail_next;
        out_count_reg  <= out_count_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        value_next      = value_reg;
        len_next        = len_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        idx_next        = idx_reg;
        pend_next       = 1'b0;
        pend_idx_next   = pend_idx_reg;
        prev_next       = prev_reg;
        unsorted_next   = unsorted_reg;
        found_next      = found_reg;
        pos_next        = pos_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_head_next   = out_head_reg;
        out_tail_next   = out_tail_reg;
        out_count_next  = out_count_reg;
        mem_req         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    value_next    = $signed(s_axis_tdata);
                    idx_next      = '0;
                    found_next    = 1'b0;
                    unsorted_next = 1'b0;
                    if (s_axis_tuser[1])
                    begin
                        state_next = S_SCAN;
                    end
                    else if (list_full)
                    begin
                        status_next = ST_FULL;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        pos_next   = (s_axis_tuser == REQ_FRONT) ? '0 : len_reg;
                        idx_next   = (s_axis_tuser == REQ_FRONT) ? len_reg : '0;
                        state_next = S_SHIFT;
                    end
                end
            end

            S_SCAN:
            begin
                if (idx_reg < len_reg)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = idx_reg[IDX_W-1:0];
                    idx_next        = idx_reg + CNT_W'(1);
                    pend_next       = 1'b1;
                    pend_idx_next   = idx_reg[IDX_W-1:0];
                end
                // The word read last cycle is checked against its neighbor and
                // against the new value; the first larger entry marks the slot.
                if (pend_reg)
                begin
                    if ((pend_idx_reg != '0) && (prev_reg > rd_data))
                    begin
                        unsorted_next = 1'b1;
                    end
                    if (!found_reg && (rd_data > value_reg))
                    begin
                        found_next = 1'b1;
                        pos_next   = CNT_W'(pend_idx_reg);
                    end
                    prev_next = rd_data;
                end
                if ((idx_reg == len_reg) && !pend_reg)
                begin
                    if (unsorted_reg)
                    begin
                        status_next = ST_UNSORTED;
                        state_next  = S_DONE;
                    end
                    else if (list_full)
                    begin
                        status_next = ST_FULL;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        pos_next   = scan_pos;
                        idx_next   = len_reg - scan_pos;
                        state_next = S_SHIFT;
                    end
                end
            end

            S_SHIFT:
            begin
                // Entries move up from the tail down, one read and one write
                // in flight per cycle.
                if (idx_reg != '0)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = shift_addr[IDX_W-1:0];
                    idx_next        = idx_reg - CNT_W'(1);
                    pend_next       = 1'b1;
                    pend_idx_next   = shift_addr[IDX_W-1:0];
                end
                if (pend_reg)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = pend_idx_reg + IDX_W'(1);
                    mem_req.wr_data = rd_data;
                end
                if ((idx_reg == '0) && !pend_reg)
                begin
                    state_next = S_WRITE;
                end
            end

            S_WRITE:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = pos_reg[IDX_W-1:0];
                mem_req.wr_data = value_reg;
                len_next        = len_reg + CNT_W'(1);
                if (pos_reg == '0)
                begin
                    head_next = value_reg;
                end
                if (pos_reg == len_reg)
                begin
                    tail_next = value_reg;
                end
                status_next = ST_OK;
                state_next  = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_head_next   = (len_reg == '0) ? '0 : head_reg;
                    out_tail_next   = (len_reg == '0) ? '0 : tail_reg;
                    out_count_next  = len_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {3'b000, out_count_reg, out_tail_reg, out_head_reg};

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds the list depth");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !s_axis_tready)
        else $error("request taken while another is in progress");

    a_ok_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg == ST_OK)) |-> (out_count_reg != '0))
        else $error("successful insert reported with an empty list");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_count_reg == '0))
            |-> ((out_head_reg == '0) && (out_tail_reg == '0)))
        else $error("empty list reported with nonzero head or tail");

endmodule

`default_nettype wire

@@ sim/sorted_list_insert_top_tb.sv @@
// Self-checking testbench for sorted_list_insert_top: drives request streams with random
// gaps and back-pressure, predicts each result and compares it field by field.
// Depends on sli_pkg and the block under test.
`default_nettype none

module sorted_list_insert_top_tb;
    import sli_pkg::*;

    // The package names front and back pushes only; both remaining codes insert in order.
    localparam logic [1:0] REQ_ASCEND     = 2'd2;
    localparam logic [1:0] REQ_ASCEND_ALT = 2'd3;

    localparam int RANDOM_BLOCKS = 16;
    localparam int BLOCK_ITEMS   = 100;
    localparam int MAX_WAIT      = 9;
    localparam int LONG_HOLD     = 300;
    localparam int DRAIN_CYCLES  = 64;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct {
        status_t                  status;
        logic signed [DATA_W-1:0] head;
        logic signed [DATA_W-1:0] tail;
        logic [CNT_W-1:0]         count;
    } list_result_t;

    class list_scoreboard;
        logic signed [DATA_W-1:0] entries [DEPTH];
        int                       length = 0;
        list_result_t             pending_results [$];
        int                       errors = 0;
        int                       checked = 0;
        int                       n_inserted = 0;
        int                       n_unsorted = 0;
        int                       n_full = 0;

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        // Applies one accepted request to the list copy and queues its expected result.
        function void note_request(logic [1:0] kind, logic signed [DATA_W-1:0] value);
            list_result_t exp;
            int           pos;
            bit           in_order;
            in_order = 1'b1;
            for (int i = 1; i < length; i++)
            begin
                if (entries[i-1] > entries[i])
                    in_order = 1'b0;
            end
            // The order check is made before the full check.
            if (kind != REQ_FRONT && kind != REQ_BACK && !in_order)
            begin
                exp.status = ST_UNSORTED;
                n_unsorted++;
            end
            else if (length >= DEPTH)
            begin
                exp.status = ST_FULL;
                n_full++;
            end
            else
            begin
                if (kind == REQ_FRONT)
                    pos = 0;
                else if (kind == REQ_BACK)
                    pos = length;
                else
                begin
                    // Equal values go behind the stored ones, so arrival order is kept.
                    pos = 0;
                    while (pos < length && entries[pos] <= value)
                        pos++;
                end
                for (int i = length; i > pos; i--)
                    entries[i] = entries[i-1];
                entries[pos] = value;
                length++;
                exp.status = ST_OK;
                n_inserted++;
            end
            exp.head  = (length == 0) ? '0 : entries[0];
            exp.tail  = (length == 0) ? '0 : entries[length-1];
            exp.count = length[CNT_W-1:0];
            pending_results.push_back(exp);
        endfunction

        task check_result(logic [71:0] data, logic [1:0] user);
            list_result_t exp;
            if (pending_results.size() == 0)
            begin
                report($sformatf("result with no request pending: tdata %h tuser %h",
                                 data, user));
                return;
            end
            exp = pending_results.pop_front();
            checked++;
            if (user !== exp.status)
                report($sformatf("result %0d status %0d, expected %0d",
                                 checked, user, exp.status));
            if (data[31:0] !== exp.head)
                report($sformatf("result %0d head %0d, expected %0d",
                                 checked, $signed(data[31:0]), exp.head));
            if (data[63:32] !== exp.tail)
                report($sformatf("result %0d tail %0d, expected %0d",
                                 checked, $signed(data[63:32]), exp.tail));
            if (data[68:64] !== exp.count)
                report($sformatf("result %0d count %0d, expected %0d",
                                 checked, data[68:64], exp.count));
        endtask
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata;    // value[31:0]
    logic [1:0]   s_axis_tuser;    // req_type[1:0]
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [71:0]  m_axis_tdata;    // head_value[31:0], tail_value[63:32], entry_count[68:64]
    logic [1:0]   m_axis_tuser;    // status[1:0]

    list_scoreboard board = new();
    bit             no_gaps = 1'b0;
    int             hold_off_cycles = 0;
    int             n_sent = 0;
    int             cycle_count = 0;

    sorted_list_insert_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, board.pending_results.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata, m_axis_tuser);
    end

    // Result side: a random stall before each result unless gaps are off, or a long hold-off when asked for.
    initial
    begin : result_sink
        int wait_cycles;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_off_cycles > 0)
            begin
                wait_cycles = hold_off_cycles;
                hold_off_cycles = 0;
            end
            else
                wait_cycles = no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
            if (wait_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (wait_cycles) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_axis_tvalid && m_axis_tready));
            @(negedge clk);
        end
    end

    task send_request(logic [1:0] kind, logic [31:0] value);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= kind;
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        board.note_request(kind, value);
        n_sent++;
    endtask

    function logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = REQ_FRONT;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Build a sorted list with extremes and repeated values, the head value among them.
        send_request(REQ_ASCEND,     32'h0000_0000);
        send_request(REQ_ASCEND,     32'h0000_0000);
        send_request(REQ_ASCEND_ALT, 32'h8000_0000);
        send_request(REQ_ASCEND,     32'h7FFF_FFFF);
        send_request(REQ_ASCEND,     32'h0000_0005);
        send_request(REQ_ASCEND,     32'h0000_0005);
        send_request(REQ_ASCEND,     32'h8000_0000);
        send_request(REQ_FRONT,      32'h8000_0000);
        send_request(REQ_BACK,       32'h7FFF_FFFF);
        send_request(REQ_ASCEND,     32'hFFFF_FFFF);
        // A large value at the front breaks the order; ordered inserts are then refused.
        send_request(REQ_FRONT,      32'h0000_0007);
        send_request(REQ_ASCEND,     32'h0000_0001);
        send_request(REQ_ASCEND_ALT, 32'h0000_0001);
        send_request(REQ_BACK,       32'hAAAA_AAAA);
        send_request(REQ_BACK,       32'h5555_5555);
        send_request(REQ_BACK,       32'h8000_0000);
        send_request(REQ_BACK,       32'h0000_0000);
        send_request(REQ_BACK,       32'hFFFF_FFFF);
        // The list is full now: pushes are refused as full, ordered inserts as unsorted.
        send_request(REQ_FRONT,      32'h1234_5678);
        send_request(REQ_BACK,       32'h8765_4321);
        send_request(REQ_ASCEND,     32'h0000_0000);
        send_request(REQ_ASCEND_ALT, 32'h7FFF_FFFF);

        for (int blk = 0; blk < RANDOM_BLOCKS; blk++)
        begin
            no_gaps = (blk % 4 == 3) || (blk == 6);
            // Stall the result side for a long while so the block backs up its input.
            if (blk == 6)
                hold_off_cycles = LONG_HOLD;
            for (int n = 0; n < BLOCK_ITEMS; n++)
                send_request(2'($urandom_range(0, 3)), pick_value());
        end
        no_gaps = 1'b0;
        @(negedge clk);
        s_axis_tvalid <= 1'b0;

        while (board.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.pending_results.size() != 0)
            board.report($sformatf("%0d results never arrived",
                                   board.pending_results.size()));

        $display("Sent %0d requests over all four request codes, %s %0d-cycle output hold-off.",
                 n_sent, "with gaps, stalls and a", LONG_HOLD);
        $display("Checked %0d results: %0d inserted, %0d refused as unsorted, %0d as full.",
                 board.checked, board.n_inserted, board.n_unsorted, board.n_full);
        if (board.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
